>>> src/bsm_pkg.sv
// Shared types, opcodes and status codes for the bytecode stack machine.
`default_nettype none
package bsm_pkg;

  // Default operand stack size
  localparam int unsigned STACK_ENTRIES_DEF = 1024;

  // Opcodes
  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_ACONST    = 8'h01;
  localparam logic [7:0] OP_ICONST_M1 = 8'h02;
  localparam logic [7:0] OP_ICONST_5  = 8'h08;
  localparam logic [7:0] OP_BIPUSH    = 8'h10;
  localparam logic [7:0] OP_DUP       = 8'h59;
  localparam logic [7:0] OP_IADD      = 8'h60;
  localparam logic [7:0] OP_ISTORE_0  = 8'h3B;
  localparam logic [7:0] OP_ISTORE_1  = 8'h3C;
  localparam logic [7:0] OP_ILOAD_0   = 8'h1A;
  localparam logic [7:0] OP_ILOAD_1   = 8'h1B;
  localparam logic [7:0] OP_RETURN    = 8'hB1;
  // iconst_<n> pushes the opcode minus this bias
  localparam logic [7:0] ICONST_BIAS  = 8'h03;

  // Status codes
  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_RET   = 3'd2;
  localparam logic [2:0] ST_BAD   = 3'd3;
  localparam logic [2:0] ST_OVER  = 3'd4;
  localparam logic [2:0] ST_UNDER = 3'd5;
  localparam logic [2:0] ST_NORET = 3'd6;

  // Classified operation handed from front to back
  typedef enum logic [3:0] {
    K_NOP,
    K_PUSH_IMM,
    K_LOAD,
    K_DUP,
    K_IADD,
    K_STORE,
    K_BIPUSH,
    K_RET,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] imm;   // signed immediate for constant pushes
    logic       lidx;  // local variable index
    logic       last;  // final byte of the program
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] top_value;
    logic [10:0] depth;
    logic [31:0] local_zero;
    logic [31:0] local_one;
  } result_t;

endpackage
`default_nettype wire

>>> src/bytecode_stack_machine.sv
// Top level of the bytecode stack machine: front end, decoded-op queue and back end.
// A byte is registered in the decoded-op queue, then executed into the registered result queue;
// iadd and istore with values below the top also pass through S_FILL (one stack memory read).
// Throughput: one byte per cycle unless S_FILL or a full result queue stalls the back end;
// iadd and istore with a refill also spend S_FILL on the stack memory's single registered read port.
// Reset: synchronous, clears queues, stack count, locals and halt; stack memory is not cleared.
`default_nettype none
module bytecode_stack_machine #(
  parameter int unsigned STACK_ENTRIES = bsm_pkg::STACK_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         in_code_byte,
  input  wire logic               in_last_byte,
  output logic                    empty,
  input  wire logic               pop,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_top_value,
  output logic [10:0]             out_depth,
  output logic signed [31:0]      out_local_zero,
  output logic signed [31:0]      out_local_one
);

  bsm_pkg::item_t   q_item;
  logic             q_empty;
  logic             q_pop;
  bsm_pkg::result_t res;

  bsm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_code_byte (in_code_byte),
    .in_last_byte (in_last_byte),
    .q_item       (q_item),
    .q_empty      (q_empty),
    .q_pop        (q_pop)
  );

  bsm_exec #(
    .STACK_ENTRIES (STACK_ENTRIES)
  ) u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  // Result fields
  assign out_status     = res.status;
  assign out_top_value  = res.top_value;
  assign out_depth      = res.depth;
  assign out_local_zero = res.local_zero;
  assign out_local_one  = res.local_one;

endmodule
`default_nettype wire

>>> src/bsm_front.sv
// Front end: accepts program bytes, classifies them and queues them for execution.
`default_nettype none
module bsm_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [7:0]      in_code_byte,
  input  wire logic            in_last_byte,
  output bsm_pkg::item_t       q_item,
  output logic                 q_empty,
  input  wire logic            q_pop
);

  bsm_pkg::item_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pend_r, pend_nxt;
  bsm_pkg::item_t dec;
  logic           wr_en, rd_en;

  assign full    = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_item  = ent_r[rp_r];
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && !q_empty;

  // Classify the incoming byte; a byte after bipush is its operand
  always_comb begin
    dec.kind = bsm_pkg::K_BAD;
    dec.imm  = in_code_byte;
    dec.lidx = 1'b0;
    dec.last = in_last_byte;
    if (pend_r) begin
      dec.kind = bsm_pkg::K_PUSH_IMM;
    end else begin
      unique case (in_code_byte) inside
        bsm_pkg::OP_NOP:    dec.kind = bsm_pkg::K_NOP;
        bsm_pkg::OP_ACONST: begin
          dec.kind = bsm_pkg::K_PUSH_IMM;
          dec.imm  = 8'h00;
        end
        [bsm_pkg::OP_ICONST_M1:bsm_pkg::OP_ICONST_5]: begin
          dec.kind = bsm_pkg::K_PUSH_IMM;
          dec.imm  = in_code_byte - bsm_pkg::ICONST_BIAS;
        end
        bsm_pkg::OP_BIPUSH: dec.kind = bsm_pkg::K_BIPUSH;
        bsm_pkg::OP_DUP:    dec.kind = bsm_pkg::K_DUP;
        bsm_pkg::OP_IADD:   dec.kind = bsm_pkg::K_IADD;
        bsm_pkg::OP_ISTORE_0, bsm_pkg::OP_ISTORE_1: begin
          dec.kind = bsm_pkg::K_STORE;
          dec.lidx = (in_code_byte == bsm_pkg::OP_ISTORE_1);
        end
        bsm_pkg::OP_ILOAD_0, bsm_pkg::OP_ILOAD_1: begin
          dec.kind = bsm_pkg::K_LOAD;
          dec.lidx = (in_code_byte == bsm_pkg::OP_ILOAD_1);
        end
        bsm_pkg::OP_RETURN: dec.kind = bsm_pkg::K_RET;
        default:            dec.kind = bsm_pkg::K_BAD;
      endcase
    end
  end

  // Operand tracking; bytes after a halt are dropped by the back end anyway
  always_comb begin
    pend_nxt = pend_r;
    if (wr_en) begin
      pend_nxt = !in_last_byte && !pend_r && (in_code_byte == bsm_pkg::OP_BIPUSH);
    end
  end

  // Queue occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 2'd1;
    else if (!wr_en && rd_en) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
      pend_r <= 1'b0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) ent_r[wp_r] <= dec;
  end

endmodule
`default_nettype wire

>>> src/bsm_exec.sv
// Back end: operand stack, locals, halt state and result queue.
`default_nettype none
module bsm_exec #(
  parameter int unsigned STACK_ENTRIES = bsm_pkg::STACK_ENTRIES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bsm_pkg::item_t  q_item,
  input  wire logic            q_empty,
  output logic                 q_pop,
  output logic                 empty,
  input  wire logic            pop,
  output bsm_pkg::result_t     res
);

  localparam int unsigned AW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(STACK_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_ENTRIES);

  typedef enum logic [1:0] {
    S_EXEC = 2'b01,
    S_FILL = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  bsm_pkg::item_t   cur_r, cur_nxt, item;
  logic [CW-1:0]    cnt_r, cnt_nxt, cnt_m1, cnt_m2;
  logic [31:0]      tos_r, tos_nxt;
  logic [31:0]      loc0_r, loc0_nxt, loc1_r, loc1_nxt;
  logic [2:0]       halt_r, halt_nxt;
  logic [31:0]      pv;
  logic             done;

  // Stack memory holds every entry below the cached top
  logic [31:0]      mem [STACK_ENTRIES];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [31:0]      rd_data_r;

  // Result queue
  bsm_pkg::result_t ofifo_r [2];
  bsm_pkg::result_t rnew;
  logic             owp_r, orp_r;
  logic [1:0]       ocnt_r;
  logic             o_rd;
  logic [CW+10:0]   depth_ext;

  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);

  // Execute one operation, or finish a pop once the memory word returns
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    tos_nxt   = tos_r;
    loc0_nxt  = loc0_r;
    loc1_nxt  = loc1_r;
    halt_nxt  = halt_r;
    mem_we    = 1'b0;
    mem_wa    = cnt_m1[AW-1:0];
    q_pop     = 1'b0;
    done      = 1'b0;
    item      = cur_r;
    pv        = tos_r;
    unique case (state_r)
      S_EXEC: begin
        item = q_item;
        if (!q_empty && (ocnt_r != 2'd2)) begin
          q_pop = 1'b1;
          done  = 1'b1;
          if (halt_r == bsm_pkg::ST_RUN) begin
            case (q_item.kind)
              bsm_pkg::K_PUSH_IMM: pv = {{24{q_item.imm[7]}}, q_item.imm};
              bsm_pkg::K_LOAD:     pv = q_item.lidx ? loc1_r : loc0_r;
              default:             pv = tos_r;
            endcase
            case (q_item.kind)
              bsm_pkg::K_PUSH_IMM, bsm_pkg::K_LOAD, bsm_pkg::K_DUP: begin
                if ((q_item.kind == bsm_pkg::K_DUP) && (cnt_r == '0)) begin
                  halt_nxt = bsm_pkg::ST_UNDER;
                end else if (cnt_r == FULL_CNT) begin
                  halt_nxt = bsm_pkg::ST_OVER;
                end else begin
                  mem_we  = (cnt_r != '0);
                  tos_nxt = pv;
                  cnt_nxt = cnt_r + CW'(1);
                end
              end
              bsm_pkg::K_IADD: begin
                if (cnt_r < CW'(2)) begin
                  halt_nxt = bsm_pkg::ST_UNDER;
                end else begin
                  done      = 1'b0;
                  cur_nxt   = q_item;
                  state_nxt = S_FILL;
                end
              end
              bsm_pkg::K_STORE: begin
                if (cnt_r == '0) begin
                  halt_nxt = bsm_pkg::ST_UNDER;
                end else begin
                  if (q_item.lidx) loc1_nxt = tos_r;
                  else loc0_nxt = tos_r;
                  if (cnt_r == CW'(1)) begin
                    cnt_nxt = '0;
                  end else begin
                    done      = 1'b0;
                    cur_nxt   = q_item;
                    state_nxt = S_FILL;
                  end
                end
              end
              bsm_pkg::K_RET: halt_nxt = bsm_pkg::ST_RET;
              bsm_pkg::K_BAD: halt_nxt = bsm_pkg::ST_BAD;
              default: ;
            endcase
          end
        end
      end
      S_FILL: begin
        done      = 1'b1;
        state_nxt = S_EXEC;
        cnt_nxt   = cnt_m1;
        if (cur_r.kind == bsm_pkg::K_IADD) tos_nxt = rd_data_r + tos_r;
        else tos_nxt = rd_data_r;
      end
      default: state_nxt = S_EXEC;
    endcase
  end

  // Result reflects state after the byte, before end-of-program clearing
  always_comb begin
    depth_ext       = {11'd0, cnt_nxt};
    rnew.depth      = depth_ext[10:0];
    rnew.top_value  = (cnt_nxt != '0) ? tos_nxt : 32'd0;
    rnew.local_zero = loc0_nxt;
    rnew.local_one  = loc1_nxt;
    if (halt_nxt != bsm_pkg::ST_RUN) rnew.status = halt_nxt;
    else if (item.last) rnew.status = bsm_pkg::ST_NORET;
    else if (item.kind == bsm_pkg::K_BIPUSH) rnew.status = bsm_pkg::ST_WAIT;
    else rnew.status = bsm_pkg::ST_RUN;
  end

  // Machine state; the last byte re-arms for the next program
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EXEC;
      cnt_r   <= '0;
      loc0_r  <= 32'd0;
      loc1_r  <= 32'd0;
      halt_r  <= bsm_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
      if (done && item.last) begin
        cnt_r  <= '0;
        loc0_r <= 32'd0;
        loc1_r <= 32'd0;
        halt_r <= bsm_pkg::ST_RUN;
      end else begin
        cnt_r  <= cnt_nxt;
        loc0_r <= loc0_nxt;
        loc1_r <= loc1_nxt;
        halt_r <= halt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    cur_r <= cur_nxt;
  end

  // Stack memory: one write port, one registered read of the entry below top
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= tos_r;
    rd_data_r <= mem[cnt_m2[AW-1:0]];
  end

  // Result queue control
  assign empty = (ocnt_r == 2'd0);
  assign res   = ofifo_r[orp_r];
  assign o_rd  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (done) owp_r <= !owp_r;
      if (o_rd) orp_r <= !orp_r;
      if (done && !o_rd) ocnt_r <= ocnt_r + 2'd1;
      else if (!done && o_rd) ocnt_r <= ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (done) ofifo_r[owp_r] <= rnew;
  end

  // A refill always completes in the following cycle
  a_fill_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |=> (state_r == S_EXEC))
    else $error("stack refill did not complete");

  // The stack count never passes the memory size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= FULL_CNT))
    else $error("stack count out of range");

  // A result is never written into a full result queue
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> ((ocnt_r != 2'd2) || o_rd))
    else $error("result queue overflow");

  // The final byte leaves the machine re-armed
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (done && item.last) |=> ((halt_r == bsm_pkg::ST_RUN) && (cnt_r == '0)))
    else $error("machine not re-armed after final byte");

endmodule
`default_nettype wire
